/* src/pwt_pkg.sv */
// shared types and constants for the prewitt edge threshold block
package pwt_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 12;
	localparam int COL_W         = 10;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_REG_W  = 13;
	localparam int CUTOFF_W      = 8;
	localparam int GRAD_W        = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 24;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 4;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);
	localparam logic [CUTOFF_W-1:0]     CUTOFF_RST = CUTOFF_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_EDGE_CUTOFF  = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// line store entry: upper row and lower row at one column
	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} line_pair_t;

endpackage

/* src/prewitt_edge_threshold.sv */
// top level: prewitt 3x3 edge marker over a raster stream of red samples
// path: a completing sample passes stage 1, the window stage and the output register, each of which can stall
// throughput: one item per cycle; the input takes items while the pipe has a free slot
// line store port: one registered read at accept, one write as the item enters the window
// reset clears counters, window cells, pipe valids and loads default geometry and cutoff
// line store contents are not cleared; no clearing pass, the block is ready right after reset
module prewitt_edge_threshold #(
	parameter int MAX_WIDTH = pwt_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pwt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel_red
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pwt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [0] edge_on, [12:1] out_row,
	                                                        // [22:13] out_col, [23] zero
	output logic                          m_axis_tlast,   // frame_last
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pwt_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	// common width for column compares, wide enough for the width register and MAX_WIDTH
	localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
	localparam int HW = HEIGHT_REG_W;

	// configuration registers
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CUTOFF_W-1:0]     cutoff_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			cutoff_q <= CUTOFF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				REG_EDGE_CUTOFF:  cutoff_q <= cfg_data[CUTOFF_W-1:0];
				default: ;        // indexes beyond the list are dropped
			endcase
		end
	end

	// effective geometry, saturated to the supported range
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		priority if (WW'(width_q) < WW'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		priority if (height_q < HW'(MIN_DIM)) begin
			h_eff = HW'(MIN_DIM);
		end else if (height_q > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// pipe flow: each stage moves when the one after it is empty or moving
	logic out_v_q;
	logic v_s1;
	logic v_s2;
	logic en_out;
	logic en2;
	logic en1;
	logic acc;
	logic mv1;
	logic mv2;

	assign en_out        = !out_v_q || m_axis_tready;
	assign en2           = !v_s2 || en_out;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign acc           = s_axis_tvalid && en1;
	assign mv1           = v_s1 && en2;
	assign mv2           = v_s2 && en_out;

	// position of the next incoming sample
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [WW-1:0]    col_ext;
	logic [WW-1:0]    col_inc;
	logic [HW-1:0]    row_ext;
	logic [HW-1:0]    row_inc;
	logic             in_width;
	logic             produce;
	logic             frame_end;
	logic [WW-1:0]    col_anchor;
	logic [ROW_W-1:0] row_anchor;

	always_comb begin
		col_ext    = WW'(col_q);
		col_inc    = col_ext + WW'(1);
		row_ext    = HW'(row_q);
		row_inc    = row_ext + HW'(1);
		in_width   = col_ext < w_eff;
		// the window anchored two back is complete once this sample lands
		produce    = in_width && (row_q >= ROW_W'(3)) && (row_ext < h_eff)
		             && (col_ext >= WW'(3));
		frame_end  = (row_ext == h_eff - HW'(1)) && (col_ext == w_eff - WW'(1));
		col_anchor = col_ext - WW'(2);
		row_anchor = row_q - ROW_W'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// stage 1: sample, its column and the line store read
	pix_t             pix_s1;
	logic [CW-1:0]    col_s1;
	logic             inw_s1;
	logic             prod_s1;
	logic             last_s1;
	logic [ROW_W-1:0] row_o_s1;
	logic [COL_W-1:0] col_o_s1;
	line_pair_t       lines_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= s_axis_tdata[PIX_W-1:0];
			col_s1   <= col_q;
			inw_s1   <= in_width;
			prod_s1  <= produce;
			last_s1  <= frame_end;
			row_o_s1 <= row_anchor;
			col_o_s1 <= col_anchor[COL_W-1:0];
		end
	end

	// same address never read and written in one cycle: neighbors differ in column
	pwt_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (lines_s1),
		.wr_en   (mv1 && inw_s1),
		.wr_addr (col_s1),
		.wr_data ({lines_s1.lower, pix_s1})
	);

	// stage 2: window columns, a chain of cells shifting one column per sample
	logic             win_shift;
	col_t             win [3];
	col_t             win_in [3];
	logic             prod_s2;
	logic             last_s2;
	logic [ROW_W-1:0] row_o_s2;
	logic [COL_W-1:0] col_o_s2;

	assign win_shift = mv1 && inw_s1;
	assign win_in[2] = '{top: lines_s1.upper, mid: lines_s1.lower, bot: pix_s1};
	assign win_in[1] = win[2];
	assign win_in[0] = win[1];

	for (genvar g = 0; g < 3; g++) begin : g_cell
		pwt_col_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (win_shift),
			.d      (win_in[g]),
			.q      (win[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			prod_s2  <= prod_s1;
			last_s2  <= last_s1;
			row_o_s2 <= row_o_s1;
			col_o_s2 <= col_o_s1;
		end
	end

	// gradient and threshold on the settled window
	logic edge_s2;

	pwt_grad u_grad (
		.left    (win[0]),
		.center  (win[1]),
		.right   (win[2]),
		.cutoff  (cutoff_q),
		.edge_on (edge_s2)
	);

	// output register: items that make no result drop out here
	logic             edge_q;
	logic             last_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2 && prod_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			edge_q    <= edge_s2;
			last_q    <= last_s2;
			out_row_q <= row_o_s2;
			out_col_q <= col_o_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_col_q, out_row_q, edge_q};
	assign m_axis_tlast  = last_q;

	// a result always sits at least one row down from the frame top
	a_row_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_row_q != '0))
		else $error("result row anchor is zero");

	// full pipe behind a stalled result must stop the input
	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready && v_s1 && v_s2) |-> !s_axis_tready)
		else $error("input taken while pipe is full and stalled");

	// window cells only move when a sample enters the window
	a_win_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!win_shift |=> ($stable(win[0]) && $stable(win[1]) && $stable(win[2])))
		else $error("window changed without a shift");

endmodule

/* src/pwt_line_buf.sv */
// two line stores kept side by side in one memory, registered read
module pwt_line_buf #(
	parameter int DEPTH  = pwt_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output pwt_pkg::line_pair_t rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  pwt_pkg::line_pair_t wr_data
);
	import pwt_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/pwt_col_cell.sv */
// one window column cell, takes its neighbor's column on each shift
module pwt_col_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  pwt_pkg::col_t  d,
	output pwt_pkg::col_t  q
);
	import pwt_pkg::*;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

/* src/pwt_grad.sv */
// prewitt gx + gy over the window and signed compare with the cutoff
module pwt_grad (
	input  pwt_pkg::col_t              left,
	input  pwt_pkg::col_t              center,
	input  pwt_pkg::col_t              right,
	input  logic [pwt_pkg::CUTOFF_W-1:0] cutoff,
	output logic                       edge_on
);
	import pwt_pkg::*;

	// gx + gy folds to 2*br + mr + bc - 2*tl - ml - tc
	logic [GRAD_W-1:0]        pos_sum;
	logic [GRAD_W-1:0]        neg_sum;
	logic signed [GRAD_W-1:0] grad;

	always_comb begin
		pos_sum = GRAD_W'({right.bot, 1'b0}) + GRAD_W'(right.mid) + GRAD_W'(center.bot);
		neg_sum = GRAD_W'({left.top, 1'b0}) + GRAD_W'(left.mid) + GRAD_W'(center.top);
		grad    = $signed(pos_sum - neg_sum);
		edge_on = grad > $signed(GRAD_W'(cutoff));
	end

endmodule

/* bench/tb.sv */
// self-checking bench for prewitt_edge_threshold: directed frame, random frames, stalls
module tb;
	import pwt_pkg::*;

	localparam int RAND_ITEMS = 1450;
	localparam int WIDE_ITEMS = 256;
	localparam int LAT_SLACK  = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // index past the register list

	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;
	typedef enum int {TEX_NOISE, TEX_BINARY, TEX_FLAT} texture_t;

	// one result item as the block reports it
	typedef struct packed {
		logic             frame_end;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             edge_on;
	} edge_res_t;

	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		edge_res_t             want;
	} stim_row_t;

	// directed part: saturated 4x4 geometry, cutoff at its top, spare index,
	// then one frame with a bright bottom row and right column
	localparam stim_row_t DIRECTED_PLAN [0:19] = '{
		'{STEP_CFG, REG_IMAGE_WIDTH,  13'h1800, 1'b0, '0},
		'{STEP_CFG, REG_IMAGE_HEIGHT, 13'h0003, 1'b0, '0},
		'{STEP_CFG, REG_EDGE_CUTOFF,  13'h1FFF, 1'b0, '0},
		'{STEP_CFG, REG_SPARE,        13'h1FFF, 1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd0,   1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		'{STEP_PIX, '0, 13'd255, 1'b0, '0},
		// gx = gy = 510, well past 255: edge at anchor (1,1), last of frame
		'{STEP_PIX, '0, 13'd255, 1'b1, '{1'b1, 10'd1, 12'd1, 1'b1}}
	};

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// predictor state: own copy of registers, line stores, window and position
	logic [WIDTH_REG_W-1:0]  geo_width  = WIDTH_RST;
	logic [HEIGHT_REG_W-1:0] geo_height = HEIGHT_RST;
	logic [CUTOFF_W-1:0]     cut_level  = CUTOFF_RST;
	bit [PIX_W-1:0] line_above [MAX_WIDTH_DEF];
	bit [PIX_W-1:0] line_below [MAX_WIDTH_DEF];
	bit [PIX_W-1:0] win [3][3];
	int pos_row, pos_col;

	edge_res_t expected_marks [$];

	bit no_idle;
	int hold_left;
	int flat_base;
	int mismatches, results_seen, marks_on, pixels_sent, cfg_writes;

	prewitt_edge_threshold u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int sat(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int geo_w();
		return sat(int'(geo_width), MIN_DIM, MAX_WIDTH_DEF);
	endfunction

	function automatic int geo_h();
		return sat(int'(geo_height), MIN_DIM, MAX_HEIGHT);
	endfunction

	function automatic pix_t paint(input texture_t tex);
		case (tex)
			TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			TEX_FLAT:   return pix_t'(flat_base + $urandom_range(0, 24));
			default:    return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// slide the window by one sample and work out the mark it completes, if any
	task automatic advance_window(input pix_t px, output bit hit, output edge_res_t res);
		int w, h, gx, gy;
		bit [PIX_W-1:0] top, mid;
		w = geo_w();
		h = geo_h();
		hit = 1'b0;
		res = '0;
		if (pos_col < w) begin
			top = line_above[pos_col];
			mid = line_below[pos_col];
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = px;
			line_above[pos_col] = mid;
			line_below[pos_col] = px;
			if (pos_row >= 3 && pos_row <= h - 1 && pos_col >= 3) begin
				gx = 0;
				gy = 0;
				for (int k = 0; k < 3; k++) begin
					gx += int'(win[k][2]) - int'(win[k][0]);
					gy += int'(win[2][k]) - int'(win[0][k]);
				end
				hit = 1'b1;
				res.edge_on   = (gx + gy > int'(cut_level));
				res.row       = ROW_W'(pos_row - 2);
				res.col       = COL_W'(pos_col - 2);
				res.frame_end = (pos_row == h - 1 && pos_col == w - 1);
			end
		end
		// position wraps as soon as it reaches or passes the current geometry
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h)
				pos_row = 0;
		end
	endtask

	// offer one pixel, with random gaps ahead of it; returns right after the accepting edge
	task automatic send_pixel(input pix_t px, input bit typed, input edge_res_t want);
		bit hit;
		edge_res_t res;
		while (!no_idle && $urandom_range(0, 99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		advance_window(px, hit, res);
		if (hit)
			expected_marks.push_back(typed ? want : res);
		@(posedge clk);
		pixels_sent++;
	endtask

	task automatic close_frame(input texture_t tex);
		while (pos_row != 0 || pos_col != 0)
			send_pixel(paint(tex), 1'b0, '0);
	endtask

	// stop offering, let every mark drain, then cover the pipe for samples with no mark
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		wait (expected_marks.size() == 0);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  geo_width  = val[WIDTH_REG_W-1:0];
			REG_IMAGE_HEIGHT: geo_height = val[HEIGHT_REG_W-1:0];
			REG_EDGE_CUTOFF:  cut_level  = val[CUTOFF_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int w_sel, h_sel, cut, feed, base_count, phase;
		texture_t tex;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == STEP_CFG) begin
				settle();
				write_reg(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
			end else begin
				send_pixel(DIRECTED_PLAN[i].data[PIX_W-1:0], DIRECTED_PLAN[i].typed,
					DIRECTED_PLAN[i].want);
			end
		end

		// widest frame: oversized width and height saturate to 1024 x 4096,
		// a stretch of the first row, then both shrink while the frame is still open
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1025, 2047)));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(4097, 8191)));
		write_reg(REG_EDGE_CUTOFF, CFG_DATA_W'($urandom_range(0, 255)));
		repeat (WIDE_ITEMS) send_pixel(paint(TEX_NOISE), 1'b0, '0);
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
		close_frame(TEX_NOISE);

		base_count = pixels_sent;
		phase = 0;
		while (pixels_sent - base_count < RAND_ITEMS) begin
			// every phase starts with the sender paused until all marks are back
			settle();
			w_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
			h_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
			if (phase == 2) begin
				w_sel = 12;
				h_sel = 8;
			end
			case ($urandom_range(0, 3))
				0:       cut = 0;
				1:       cut = 255;
				default: cut = $urandom_range(0, 255);
			endcase
			write_reg(REG_IMAGE_WIDTH, {2'($urandom), 11'(w_sel)});
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_sel));
			write_reg(REG_EDGE_CUTOFF, {5'($urandom), 8'(cut)});
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
			no_idle = (phase >= 4 && phase < 8);
			// long receiver hold-off: the block fills up and must stall its input
			if (phase == 2)
				hold_left = 400;
			tex = texture_t'($urandom_range(0, 2));
			flat_base = $urandom_range(0, 231);
			if (phase % 4 == 3) begin
				// geometry shrinks part way into a frame
				feed = $urandom_range(1, geo_w() * geo_h() - 1);
				repeat (feed) send_pixel(paint(tex), 1'b0, '0);
				settle();
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(4, geo_w())));
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(4, geo_h())));
				close_frame(tex);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					send_pixel(paint(tex), 1'b0, '0);
					close_frame(tex);
				end
			end
			phase++;
		end
		no_idle = 1'b0;

		settle();
		$display("run covered %0d pixels and %0d register writes, %0d marks checked (%0d edges)",
			pixels_sent, cfg_writes, results_seen, marks_on);
		$display("geometry from saturated 4x4 to 1024 wide, with mid-frame shrinks and stalls");
		if (mismatches == 0 && expected_marks.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls, a counted hold-off on request
	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 30);
			end
		end
	end

	// outputs are sampled mid-cycle, ahead of the edge that takes the item
	always @(negedge clk) begin : check_marks
		edge_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.edge_on   = m_axis_tdata[0];
			got.row       = m_axis_tdata[ROW_W:1];
			got.col       = m_axis_tdata[ROW_W+COL_W:ROW_W+1];
			got.frame_end = m_axis_tlast;
			results_seen++;
			if (expected_marks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: edge_on=%0d row=%0d col=%0d last=%0d",
						got.edge_on, got.row, got.col, got.frame_end);
			end else begin
				want = expected_marks.pop_front();
				if (want.edge_on)
					marks_on++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected edge_on=%0d row=%0d col=%0d last=%0d, ",
							"got edge_on=%0d row=%0d col=%0d last=%0d"},
							want.edge_on, want.row, want.col, want.frame_end,
							got.edge_on, got.row, got.col, got.frame_end);
				end
			end
		end
	end

	initial begin : watchdog
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
